[hw/rtl/gmts_pkg.sv]
package gmts_pkg;

  localparam int unsigned MAX_CLASSES_DEF = 65536;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  // Magnitude of log2(ln 2) in Q.32; the value itself is negative.
  localparam logic [31:0] LOG2_LN2_MAG = 32'd2271034279;
  localparam logic [24:0] ONE_Q24      = 25'd16777216;
  localparam logic [15:0] INV_T_RESET  = 16'd256;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
  // The divide by three runs as two reciprocal multiplies, one per cycle.
  localparam logic [5:0]  DIV_STEPS    = 6'd2;
  // ceil(2^18 / 3) serves any 17-bit dividend; ceil(2^21 / 3) any dividend below 2^20.
  localparam logic [16:0] RECIP3_Q18   = 17'd87382;
  localparam logic [19:0] RECIP3_Q21   = 20'd699051;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOGP,
    OP_MULA,
    OP_WW,
    OP_WWW,
    OP_DIV,
    OP_LOGT,
    OP_LOGU,
    OP_LOGV,
    OP_S,
    OP_Q,
    OP_CMP
  } dp_op_t;

  typedef struct packed {
    logic log_busy;
    logic div_last;
    logic p_zero;
    logic small_w;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

[hw/rtl/gmts_ifs.sv]
interface gmts_class_if;
  logic        valid;
  logic        ready;
  logic [24:0] probability;
  logic [31:0] uniform_sample;
  logic        last_class;
  modport source (output valid, probability, uniform_sample, last_class, input ready);
  modport sink (input valid, probability, uniform_sample, last_class, output ready);
endinterface

interface gmts_result_if;
  logic               valid;
  logic               ready;
  logic        [15:0] chosen_index;
  logic signed [31:0] winning_score;
  modport source (output valid, chosen_index, winning_score, input ready);
  modport sink (input valid, chosen_index, winning_score, output ready);
endinterface

[hw/rtl/gmts_log2.sv]
module gmts_log2
  import gmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic        busy,
  output logic [63:0] res
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_ITER} lstate_t;

  lstate_t     state;
  logic [63:0] n;
  logic [5:0]  e;
  logic [31:0] m;
  logic [31:0] frac;
  logic [4:0]  it;
  logic [63:0] sq;
  logic [32:0] m2;

  assign sq   = 64'(m) * 64'(m);
  assign m2   = sq[63:31];
  assign busy = (state != L_IDLE);
  assign res  = {26'd0, e, frac};

  // Normalize one bit per cycle, then square-and-compare one fraction bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            n     <= (v == 64'd0) ? 64'd1 : v;
            e     <= 6'd63;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (n[63]) begin
            m     <= n[63:32];
            frac  <= 32'd0;
            it    <= 5'd31;
            state <= L_ITER;
          end else begin
            n <= {n[62:0], 1'b0};
            e <= e - 6'd1;
          end
        end
        L_ITER: begin
          frac <= {frac[30:0], m2[32]};
          m    <= m2[32] ? m2[32:1] : m2[31:0];
          it   <= it - 5'd1;
          if (it == 5'd0) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/gmts_datapath.sv]
module gmts_datapath
  import gmts_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_op_t               op,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic [24:0]          probability,
  input  logic [31:0]          uniform_sample,
  input  logic                 last_class,
  gmts_result_if.source        result
);

  localparam int unsigned CW = $clog2(MAX_CLASSES);

  logic [15:0]        inv_t;
  logic [24:0]        p;
  logic [31:0]        u;
  logic [32:0]        w;
  logic               last;
  logic [44:0]        a;
  logic [47:0]        ww;
  logic [34:0]        div_sh;
  logic [34:0]        quot;
  logic [1:0]         rem;
  logic [5:0]         div_cnt;
  logic [48:0]        mag;
  logic [32:0]        q;
  logic               neg;
  logic signed [31:0] best_score;
  logic [CW-1:0]      best_index;
  logic [CW-1:0]      cnt;
  logic               out_valid;
  logic [15:0]        out_index;
  logic signed [31:0] out_score;

  logic               log_start;
  logic [63:0]        log_v;
  logic               log_busy;
  logic [63:0]        log_res;

  logic [24:0]        p_in;
  logic [31:0]        u_in;
  logic [36:0]        lp_mag;
  logic [52:0]        a_prod;
  logic [47:0]        x_prod;
  logic [33:0]        hi_prod;
  logic [16:0]        hi_q;
  logic [17:0]        hi_m3;
  logic [16:0]        hi_diff;
  logic [19:0]        lo_num;
  logic [39:0]        lo_prod;
  logic [17:0]        lo_q;
  logic [51:0]        t_val;
  logic signed [51:0] lt;
  logic signed [51:0] s;
  logic [51:0]        s_mag;
  logic [64:0]        q_prod;
  logic signed [31:0] score;
  logic [CW+15:0]     idx_ext;
  logic [CW+15:0]     cnt_ext;

  gmts_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .v     (log_v),
    .busy  (log_busy),
    .res   (log_res)
  );

  assign p_in    = (probability > ONE_Q24) ? ONE_Q24 : probability;
  assign u_in    = (uniform_sample == 32'd0) ? 32'd1 : uniform_sample;
  assign lp_mag  = 37'(38'd24 << 32) - log_res[36:0];
  assign a_prod  = 53'(lp_mag) * 53'(inv_t);
  assign x_prod  = 48'(ww[47:24]) * 48'(w[23:0]);
  assign t_val   = 52'({w[23:0], 27'd0}) + 52'(ww[47:6]) + 52'(quot);

  // Divide by three in two halves: the upper 17 bits first, then the remainder joined
  // with the lower 18 bits. Both quotients come from reciprocal multiplies.
  assign hi_prod = 34'(div_sh[34:18]) * 34'(RECIP3_Q18);
  assign hi_q    = 17'(hi_prod[33:18]);
  assign hi_m3   = {hi_q, 1'b0} + {1'b0, hi_q};
  assign hi_diff = div_sh[34:18] - hi_m3[16:0];
  assign lo_num  = {rem, div_sh[17:0]};
  assign lo_prod = 40'(lo_num) * 40'(RECIP3_Q21);
  assign lo_q    = lo_prod[38:21];

  always_comb begin
    log_start = 1'b0;
    log_v     = 64'(p);
    case (op)
      OP_LOGP: log_start = 1'b1;
      OP_LOGT: begin
        log_start = 1'b1;
        log_v     = 64'(t_val);
      end
      OP_LOGU: begin
        log_start = 1'b1;
        log_v     = 64'(u);
      end
      OP_LOGV: begin
        log_start = 1'b1;
        log_v     = (64'd32 << 32) - log_res;
      end
      default: log_start = 1'b0;
    endcase
  end

  // Log-domain score: lt = log2(-ln u), s = -a - lt.
  always_comb begin
    if (w[32:24] == 9'd0) begin
      lt = $signed({14'd0, log_res[37:0]}) - $signed(52'd59 << 32);
    end else begin
      lt = $signed({14'd0, log_res[37:0]}) - $signed(52'd32 << 32)
           - $signed(52'(LOG2_LN2_MAG));
    end
    s     = -$signed({7'd0, a}) - lt;
    s_mag = s[51] ? 52'(-s) : 52'(s);
  end

  assign q_prod = 65'(mag[48:16]) * 65'(LN2_Q32);

  always_comb begin
    if (p == 25'd0) begin
      score = SCORE_MIN;
    end else if (neg) begin
      score = (q >= 33'h0_8000_0000) ? SCORE_MIN : -$signed(q[31:0]);
    end else begin
      score = (q > 33'h0_7FFF_FFFF) ? SCORE_MAX : $signed(q[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        p    <= p_in;
        u    <= u_in;
        w    <= 33'h1_0000_0000 - 33'(u_in);
        last <= last_class;
      end
      OP_MULA: a  <= a_prod[52:8];
      OP_WW:   ww <= 48'(w[23:0]) * 48'(w[23:0]);
      OP_WWW:  begin
        div_sh <= x_prod[47:13];
        quot   <= 35'd0;
        rem    <= 2'd0;
      end
      OP_DIV: begin
        if (div_cnt == DIV_STEPS) begin
          quot[34:18] <= hi_q;
          rem         <= hi_diff[1:0];
        end else begin
          quot[17:0]  <= lo_q;
        end
      end
      OP_S: begin
        neg <= s[51];
        mag <= (s_mag > 52'(52'd1 << 48)) ? 49'(49'd1 << 48) : s_mag[48:0];
      end
      OP_Q:    q <= q_prod[64:32];
      default: neg <= neg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 6'd0;
    end else if (op == OP_WWW) begin
      div_cnt <= DIV_STEPS;
    end else if (op == OP_DIV) begin
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_t <= INV_T_RESET;
    end else if (cfg_we) begin
      inv_t <= cfg_wdata;
    end
  end

  assign idx_ext = {16'd0, best_index};
  assign cnt_ext = {16'd0, cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= SCORE_MIN;
      best_index <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (op == OP_CMP && last) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (op == OP_CMP) begin
        if (last) begin
          out_index  <= (score > best_score) ? cnt_ext[15:0] : idx_ext[15:0];
          out_score  <= (score > best_score) ? score : best_score;
          best_score <= SCORE_MIN;
          best_index <= '0;
          cnt        <= '0;
        end else begin
          cnt <= (cnt == CW'(MAX_CLASSES - 1)) ? '0 : cnt + 1'b1;
          if (score > best_score) begin
            best_score <= score;
            best_index <= cnt;
          end
        end
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.chosen_index  = out_index;
  assign result.winning_score = out_score;

  assign status.log_busy = log_busy;
  assign status.div_last = (div_cnt == 6'd1);
  assign status.p_zero   = (p == 25'd0);
  assign status.small_w  = (w[32:24] == 9'd0);
  assign status.last     = last;
  assign status.out_busy = out_valid && !result.ready;

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CMP && last) |=> (best_score == SCORE_MIN && cnt == '0))
    else $error("state not cleared after last class");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CMP && last) |=> out_valid)
    else $error("no result after last class");

  a_log_idle_start: assert property (@(posedge clk) disable iff (rst)
    log_start |-> !log_busy)
    else $error("log unit started while busy");

endmodule

[hw/rtl/gmts_ctrl.sv]
module gmts_ctrl
  import gmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LOGP_W, S_MULA, S_WW, S_WWW, S_DIV, S_LOGT, S_LOGT_W,
    S_LOGU, S_LOGU_W, S_LOGV, S_LOGV_W, S_S, S_Q, S_CMP
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:  op = in_valid ? OP_LOAD : OP_NONE;
      S_CHK:   op = status.p_zero ? OP_NONE : OP_LOGP;
      S_MULA:  op = OP_MULA;
      S_WW:    op = OP_WW;
      S_WWW:   op = OP_WWW;
      S_DIV:   op = OP_DIV;
      S_LOGT:  op = OP_LOGT;
      S_LOGU:  op = OP_LOGU;
      S_LOGV:  op = OP_LOGV;
      S_S:     op = OP_S;
      S_Q:     op = OP_Q;
      S_CMP:   op = (status.last && status.out_busy) ? OP_NONE : OP_CMP;
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_CHK;
        S_CHK:    state <= status.p_zero ? S_CMP : S_LOGP_W;
        S_LOGP_W: if (!status.log_busy) state <= S_MULA;
        S_MULA:   state <= status.small_w ? S_WW : S_LOGU;
        S_WW:     state <= S_WWW;
        S_WWW:    state <= S_DIV;
        S_DIV:    if (status.div_last) state <= S_LOGT;
        S_LOGT:   state <= S_LOGT_W;
        S_LOGT_W: if (!status.log_busy) state <= S_S;
        S_LOGU:   state <= S_LOGU_W;
        S_LOGU_W: if (!status.log_busy) state <= S_LOGV;
        S_LOGV:   state <= S_LOGV_W;
        S_LOGV_W: if (!status.log_busy) state <= S_S;
        S_S:      state <= S_Q;
        S_Q:      state <= S_CMP;
        S_CMP:    if (!(status.last && status.out_busy)) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_idle_log_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !status.log_busy)
    else $error("log unit busy while idle");

  a_accept_then_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHK))
    else $error("accepted word not processed");

  a_hold_for_sink: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && status.last && status.out_busy) |=> (state == S_CMP))
    else $error("last word compared while the previous result is held");

endmodule

[hw/rtl/gumbel_max_token_sampler.sv]
// A zero probability is scored without any log; any other word waits on the shared
// bit-serial log2 unit (normalize steps plus 32 square steps per log): two logs for
// samples close to 1.0, three otherwise.
// One class word at a time: the next word is taken only once the last one is scored; a last
// word also waits while the previous result is still held by the sink.
// Reset (rst, synchronous, active high) clears best score, index and class counter and
// loads inverse temperature 256 (1.0). No clearing pass is needed.
module gumbel_max_token_sampler
  import gmts_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gmts_class_if.sink    classes,
  gmts_result_if.source result,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  // The controller walks each word through the scoring steps; the datapath owns the
  // arithmetic, the running maximum and the result register, so a finished result can
  // wait for the sink while the next word is already being scored.
  dp_op_t     op;
  dp_status_t status;

  gmts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (classes.valid),
    .in_ready (classes.ready),
    .status   (status),
    .op       (op)
  );

  gmts_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .probability    (classes.probability),
    .uniform_sample (classes.uniform_sample),
    .last_class     (classes.last_class),
    .result         (result)
  );

endmodule

[tb/gmts_score_checker.sv]
`timescale 1ns / 1ps

module gmts_score_checker
  import gmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        cls_valid,
  input  logic        cls_ready,
  input  logic [24:0] cls_probability,
  input  logic [31:0] cls_uniform,
  input  logic        cls_last,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [15:0] res_index,
  input  logic [31:0] res_score,
  output int          error_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic [15:0] index;
    logic [31:0] score;
  } winner_t;

  winner_t pending_winners[$];
  logic [15:0]        inv_temp;
  logic signed [31:0] top_score;
  logic [15:0]        top_index;
  logic [15:0]        class_num;

  function automatic logic [63:0] log2_q32(logic [63:0] v);
    int e;
    logic [63:0] m;
    logic [127:0] sq;
    logic [31:0] frac;
    e = 63;
    frac = '0;
    if (v == 64'd0) v = 64'd1;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 31) m = v >> (e - 31);
    else m = v << (31 - e);
    m = m & 64'hFFFF_FFFF;
    for (int i = 31; i >= 0; i--) begin
      sq = 128'(m) * 128'(m);
      m = 64'(sq >> 31);
      if (m >= 64'h1_0000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return {e[31:0], frac};
  endfunction

  function automatic logic signed [31:0] perturbed_score(logic [24:0] p_in, logic [31:0] u_in,
                                                         logic [15:0] inv_t);
    logic [63:0] p, u, w, ww, t, v, mag, amp, lp_mag;
    logic [127:0] prod;
    logic signed [63:0] lp, lt, s;
    p = 64'(p_in);
    u = 64'(u_in);
    if (p > 64'(ONE_Q24)) p = 64'(ONE_Q24);
    if (p == 64'd0) return SCORE_MIN;
    lp = $signed(log2_q32(p)) - (64'sd24 <<< 32);
    lp_mag = 64'(-lp);
    prod = 128'(lp_mag) * 128'(inv_t);
    amp = 64'(prod >> 8);
    if (u == 64'd0) u = 64'd1;
    w = 64'h1_0000_0000 - u;
    if (w < (64'd1 << 24)) begin
      ww = w * w;
      t = (w << 27) + (ww >> 6) + ((((ww >> 24) * w) / 64'd3) >> 13);
      lt = $signed(log2_q32(t)) - (64'sd59 <<< 32);
    end else begin
      v = (64'd32 << 32) - log2_q32(u);
      lt = $signed(log2_q32(v)) - (64'sd32 <<< 32) - $signed({32'd0, LOG2_LN2_MAG});
    end
    s = -$signed(amp) - lt;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    if (mag > (64'd1 << 48)) mag = 64'd1 << 48;
    prod = 128'(mag >> 16) * 128'(LN2_Q32);
    mag = 64'(prod >> 32);
    if (s < 0) begin
      if (mag >= 64'h8000_0000) return SCORE_MIN;
      return -$signed(mag[31:0]);
    end
    if (mag > 64'h7FFF_FFFF) return SCORE_MAX;
    return $signed(mag[31:0]);
  endfunction

  assign pending_count = pending_winners.size();

  always @(posedge clk) begin
    logic signed [31:0] sc;
    logic signed [31:0] cand_score;
    logic [15:0]        cand_index;
    winner_t got, want;
    if (rst) begin
      inv_temp <= INV_T_RESET;
      top_score <= SCORE_MIN;
      top_index <= '0;
      class_num <= '0;
      error_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) inv_temp <= cfg_wdata;
      if (cls_valid && cls_ready) begin
        sc = perturbed_score(cls_probability, cls_uniform, inv_temp);
        cand_score = top_score;
        cand_index = top_index;
        // Equal scores keep the earlier class.
        if (sc > top_score) begin
          cand_score = sc;
          cand_index = class_num;
        end
        if (cls_last) begin
          pending_winners = {pending_winners, winner_t'({cand_index, cand_score})};
          top_score <= SCORE_MIN;
          top_index <= '0;
          class_num <= '0;
        end else begin
          top_score <= cand_score;
          top_index <= cand_index;
          class_num <= class_num + 16'd1;
        end
      end
      if (res_valid && res_ready) begin
        got = {res_index, res_score};
        result_count <= result_count + 1;
        if (pending_winners.size() == 0) begin
          $display("%0t: unexpected result index %0d score %0d", $time, res_index,
                   $signed(res_score));
          error_count <= error_count + 1;
        end else begin
          want = pending_winners.pop_front();
          if (got.index !== want.index || got.score !== want.score) begin
            $display("%0t: expected index %0d score %0d, actual index %0d score %0d", $time,
                     want.index, $signed(want.score), got.index, $signed(got.score));
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb_gumbel_max_token_sampler.sv]
`timescale 1ns / 1ps

module tb_gumbel_max_token_sampler
  import gmts_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          error_count, pending_count, result_count;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  int          word_count = 0;

  gmts_class_if  cls_if ();
  gmts_result_if res_if ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gumbel_max_token_sampler i_dut (
    .clk      (clk),
    .rst      (rst),
    .classes  (cls_if.sink),
    .result   (res_if.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  gmts_score_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cls_valid      (cls_if.valid),
    .cls_ready      (cls_if.ready),
    .cls_probability(cls_if.probability),
    .cls_uniform    (cls_if.uniform_sample),
    .cls_last       (cls_if.last_class),
    .res_valid      (res_if.valid),
    .res_ready      (res_if.ready),
    .res_index      (res_if.chosen_index),
    .res_score      (res_if.winning_score),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .result_count   (result_count)
  );

  // The receiver stalls at random with the chance set by the current phase.
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // A watchdog ends the run if no word moves on either channel for too long.
  // The limit lies far above the slowest word, so this leaves a wide margin.
  always @(posedge clk) begin
    if ((cls_if.valid && cls_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sends one class word; the sender first idles at random per the phase.
  // Valid stays high after the handshake until the next idle or drain.
  task automatic send_word(logic [24:0] p, logic [31:0] u, logic last);
    if ($urandom_range(99) < idle_pct) begin
      cls_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    cls_if.valid <= 1'b1;
    cls_if.probability <= p;
    cls_if.uniform_sample <= u;
    cls_if.last_class <= last;
    @(posedge clk);
    while (!cls_if.ready) @(posedge clk);
    word_count++;
  endtask

  // Waits until every winner is back, then lets the block drain its last word.
  task automatic drain();
    cls_if.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_inv_temp(logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random probability: mostly plausible values, sometimes zero, one or above one.
  function automatic logic [24:0] rand_prob();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_Q24;
      2: return 25'($urandom);
      3: return 25'($urandom_range(255));
      default: return 25'($urandom_range(16777216, 1));
    endcase
  endfunction

  // Random sample: includes values near one, which take the series path.
  function automatic logic [31:0] rand_unif();
    case ($urandom_range(7))
      0: return 32'hFFFF_FFFF - $urandom_range(16777215);
      1: return $urandom_range(1000);
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_distributions(int words);
    int len;
    int sent;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        send_word(rand_prob(), rand_unif(), k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] temps[5];
    cls_if.valid = 1'b0;
    cls_if.probability = '0;
    cls_if.uniform_sample = '0;
    cls_if.last_class = 1'b0;
    temps = '{16'd1, 16'd65535, 16'd0, 16'd128, 16'd4096};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset temperature: field extremes and special cases.
    send_word(ONE_Q24, 32'hFFFF_FFFF, 1'b1);
    send_word('0, 32'd1, 1'b1);
    send_word('0, 32'h8000_0000, 1'b0);
    send_word('0, 32'hFFFF_FFFF, 1'b1);
    send_word(25'h1FF_FFFF, 32'd1, 1'b0);
    send_word(25'd1, 32'h1234_5678, 1'b0);
    send_word(ONE_Q24, 32'd0, 1'b1);
    send_word(25'd8388608, 32'h8000_0000, 1'b0);
    send_word(25'd8388608, 32'h8000_0000, 1'b1);
    send_word(25'd1000, 32'hFFFF_FF00, 1'b0);
    send_word(25'd1, 32'hFF00_0000, 1'b1);

    // Extreme and ordinary temperatures, each with random traffic and a new idle phase.
    for (int ph = 0; ph < 5; ph++) begin
      write_inv_temp(temps[ph]);
      send_word(25'd1, 32'd1, 1'b0);
      send_word(ONE_Q24, 32'hFFFF_FFFE, 1'b1);
      case (ph)
        1: begin idle_pct = 72; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 72; end
        3: begin idle_pct = 38; stall_pct = 38; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      random_distributions(265);
    end
    write_inv_temp(INV_T_RESET);
    idle_pct = 0;
    stall_pct = 0;
    random_distributions(20);
    drain();

    $display("Sent %0d class words over six temperature settings and four idle phases.",
             word_count);
    $display("Checked %0d winners against the predicted index and score.", result_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
